[sv/bwm_pkg.sv]
// ----------------------------------------------------------------------------
// bwm_pkg
// Shared codes, widths and the queue entry type of the byte/word data memory.
// ----------------------------------------------------------------------------
`default_nettype none

package bwm_pkg;

  localparam int MEM_WORDS_DEF = 4096;

  localparam int OP_W    = 3;
  localparam int BASE_W  = 14;
  localparam int OFF_W   = 12;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  // Byte address of base + offset, signed: a carry bit and a sign bit above the base range.
  localparam int ADDR_W  = BASE_W + 2;
  localparam int WIDX_W  = ADDR_W - 2;

  localparam logic [OP_W-1:0] OP_LW  = 3'd0;
  localparam logic [OP_W-1:0] OP_LB  = 3'd1;
  localparam logic [OP_W-1:0] OP_LBU = 3'd2;
  localparam logic [OP_W-1:0] OP_SW  = 3'd3;
  localparam logic [OP_W-1:0] OP_SB  = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_ALIGN = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Work the back end has to do for one beat.
  typedef enum logic [2:0] {
    ACC_NONE = 3'd0,
    ACC_LW   = 3'd1,
    ACC_LB   = 3'd2,
    ACC_LBU  = 3'd3,
    ACC_SW   = 3'd4,
    ACC_SB   = 3'd5
  } acc_t;

  typedef struct packed {
    acc_t              acc;
    status_t           status;
    logic [WIDX_W-1:0] widx;
    logic [1:0]        lane;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[sv/bwm_front.sv]
// ----------------------------------------------------------------------------
// bwm_front
// Accepts input beats, forms the byte address and classifies each access.
// ----------------------------------------------------------------------------
`default_nettype none

module bwm_front #(
  parameter int MEMORY_WORDS = bwm_pkg::MEM_WORDS_DEF
) (
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bwm_pkg::OP_W-1:0]    in_op,
  input  wire logic [bwm_pkg::BASE_W-1:0]  in_base_address,
  input  wire logic [bwm_pkg::OFF_W-1:0]   in_offset,
  input  wire logic [bwm_pkg::DATA_W-1:0]  in_store_value,
  input  wire bwm_pkg::q_stat_t            q_stat,
  output logic                             push,
  output bwm_pkg::entry_t                  push_entry
);
  import bwm_pkg::*;

  logic [ADDR_W-1:0] addr;
  logic [WIDX_W-1:0] widx;
  logic              is_word;
  logic              is_byte;
  logic              bad_align;
  logic              bad_range;
  acc_t              acc;

  assign addr = {2'b00, in_base_address}
              + {{(ADDR_W-OFF_W){in_offset[OFF_W-1]}}, in_offset};
  assign widx = addr[ADDR_W-1:2];

  always_comb begin
    is_word = 1'b0;
    is_byte = 1'b0;
    acc     = ACC_NONE;
    unique case (in_op)
      OP_LW:   begin is_word = 1'b1; acc = ACC_LW;  end
      OP_SW:   begin is_word = 1'b1; acc = ACC_SW;  end
      OP_LB:   begin is_byte = 1'b1; acc = ACC_LB;  end
      OP_LBU:  begin is_byte = 1'b1; acc = ACC_LBU; end
      OP_SB:   begin is_byte = 1'b1; acc = ACC_SB;  end
      default: acc = ACC_NONE;
    endcase
  end

  // Alignment is checked before range.
  assign bad_align = (is_word && (addr[1:0] != 2'b00))
                  || (is_byte && ((in_base_address[1:0] != 2'b00) || in_offset[OFF_W-1]));
  assign bad_range = addr[ADDR_W-1]
                  || ({{(32-WIDX_W){1'b0}}, widx} >= 32'(MEMORY_WORDS));

  always_comb begin
    push_entry.acc    = acc;
    push_entry.status = ST_OK;
    push_entry.widx   = widx;
    push_entry.lane   = addr[1:0];
    push_entry.data   = in_store_value;
    if (is_word || is_byte) begin
      if (bad_align) begin
        push_entry.status = ST_ALIGN;
        push_entry.acc    = ACC_NONE;
      end else if (bad_range) begin
        push_entry.status = ST_RANGE;
        push_entry.acc    = ACC_NONE;
      end
    end
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

endmodule

`default_nettype wire

[sv/bwm_fifo.sv]
// ----------------------------------------------------------------------------
// bwm_fifo
// Two-entry queue of classified accesses between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bwm_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bwm_pkg::entry_t  push_entry,
  input  wire logic             pop,
  output bwm_pkg::entry_t       pop_entry,
  output bwm_pkg::q_stat_t      q_stat
);
  import bwm_pkg::*;

  entry_t     slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry    = slot_r[rd_ptr_r];
  assign q_stat.full  = count_r[1];
  assign q_stat.empty = (count_r == 2'd0);

endmodule

`default_nettype wire

[sv/bwm_back.sv]
// ----------------------------------------------------------------------------
// bwm_back
// Executes queued accesses against the word memory and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bwm_back #(
  parameter int MEMORY_WORDS = bwm_pkg::MEM_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bwm_pkg::q_stat_t            q_stat,
  input  wire bwm_pkg::entry_t             pop_entry,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bwm_pkg::DATA_W-1:0]       out_load_value,
  output logic [bwm_pkg::STAT_W-1:0]       out_status
);
  import bwm_pkg::*;

  localparam int AW = $clog2(MEMORY_WORDS);

  typedef enum logic [1:0] {
    BS_IDLE = 2'b01,
    BS_READ = 2'b10
  } bstate_t;

  bstate_t             state_r, state_nxt;
  entry_t              cur_r;
  logic [DATA_W-1:0]   mem [MEMORY_WORDS];
  logic [DATA_W-1:0]   rd_data_r;

  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  status_t             out_status_r, out_status_nxt;

  logic                out_free;
  logic                needs_read;
  logic                mem_re;
  logic                mem_we;
  logic [AW-1:0]       mem_raddr;
  logic [AW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [31:0]         head_idx;
  logic [31:0]         cur_idx;
  logic [4:0]          shamt;
  logic [7:0]          sel_byte;
  logic [DATA_W-1:0]   merged;

  assign out_free = !out_valid_r || out_ready;
  assign head_idx = 32'(pop_entry.widx);
  assign cur_idx  = 32'(cur_r.widx);
  assign shamt    = {cur_r.lane, 3'b000};
  assign sel_byte = rd_data_r[shamt +: 8];

  always_comb begin
    merged             = rd_data_r;
    merged[shamt +: 8] = cur_r.data[7:0];
  end

  always_comb begin
    needs_read = 1'b0;
    case (pop_entry.acc) inside
      ACC_LW, ACC_LB, ACC_LBU, ACC_SB: needs_read = 1'b1;
      default:                         needs_read = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    pop            = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = head_idx[AW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = head_idx[AW-1:0];
    mem_wdata      = pop_entry.data;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      BS_IDLE: begin
        if (!q_stat.empty && out_free) begin
          pop = 1'b1;
          if (needs_read) begin
            mem_re    = 1'b1;
            state_nxt = BS_READ;
          end else begin
            mem_we         = (pop_entry.acc == ACC_SW);
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = pop_entry.status;
          end
        end
      end
      BS_READ: begin
        // Hold the read word until the result register frees up.
        if (out_free) begin
          state_nxt      = BS_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = '0;
          case (cur_r.acc)
            ACC_LW:  out_value_nxt = rd_data_r;
            ACC_LB:  out_value_nxt = {{(DATA_W-8){sel_byte[7]}}, sel_byte};
            ACC_LBU: out_value_nxt = {{(DATA_W-8){1'b0}}, sel_byte};
            ACC_SB: begin
              mem_we    = 1'b1;
              mem_waddr = cur_idx[AW-1:0];
              mem_wdata = merged;
            end
            default: out_value_nxt = '0;
          endcase
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    if (pop) begin
      cur_r <= pop_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_load_value = out_value_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

[sv/byte_word_load_store_memory.sv]
// ----------------------------------------------------------------------------
// byte_word_load_store_memory
// Word-organized data memory serving word and byte loads and stores.
// ----------------------------------------------------------------------------
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid/in_ready, in_op, in_base_address,         | in
//          | in_offset, in_store_value                          |
//  result  | out_valid/out_ready, out_load_value, out_status    | out
//
//  An error, store word or unused op is done in BS_IDLE; a load or byte store
//  also needs BS_READ, as the memory read port is registered and a byte store
//  is read-modify-write on the single memory. The two-entry queue lets input
//  beats be taken while the back end works or the result beat is stalled.
//  Reset clears control only; memory contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_word_load_store_memory #(
  parameter int MEMORY_WORDS = bwm_pkg::MEM_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bwm_pkg::OP_W-1:0]    in_op,
  input  wire logic [bwm_pkg::BASE_W-1:0]  in_base_address,
  input  wire logic [bwm_pkg::OFF_W-1:0]   in_offset,
  input  wire logic [bwm_pkg::DATA_W-1:0]  in_store_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bwm_pkg::DATA_W-1:0]       out_load_value,
  output logic [bwm_pkg::STAT_W-1:0]       out_status
);
  import bwm_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  pop_entry;

  bwm_front #(.MEMORY_WORDS(MEMORY_WORDS)) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_base_address (in_base_address),
    .in_offset       (in_offset),
    .in_store_value  (in_store_value),
    .q_stat          (q_stat),
    .push            (push),
    .push_entry      (push_entry)
  );

  bwm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  bwm_back #(.MEMORY_WORDS(MEMORY_WORDS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop_entry      (pop_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_load_value (out_load_value),
    .out_status     (out_status)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_load_value == '0))
    else $error("error beat carries nonzero load value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !pop) |=> !q_stat.empty)
    else $error("queue lost an entry");

endmodule

`default_nettype wire
